// ===== design/length_prefixed_frame_splitter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Frame splitter assertion macros
// Clocked, reset-gated assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_UNIT_MACROS_SVH

// Property checked on every rising edge of clock, off while reset is high.
`define LPFS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication: when cond holds, prop must hold on the same edge.
`define LPFS_ASSERT_IMPL(label, cond, prop, msg) \
   `LPFS_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ===== design/lpfs_pkg.sv =====
// ---------------------------------------------------------------------------
// lpfs_pkg
// Shared types and constants of the length-prefixed frame splitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfs_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int CMD_W       = 7;
   localparam int LEN_W       = 32;
   localparam int MAX_LEN_W   = 18;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BIG_ENDIAN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_FRAME    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_COMMANDS = 2'd2;

   // Register reset values
   localparam logic [MAX_LEN_W-1:0] MAX_FRAME_RESET    = 18'd131072;
   localparam logic [CMD_W-1:0]     NUM_COMMANDS_RESET = 7'd28;

   // Byte roles
   localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DROP = 2'd3;

   typedef enum logic [1:0] {
      PH_CMD = 2'd0,
      PH_LEN = 2'd1,
      PH_PAY = 2'd2
   } phase_type;

   typedef struct packed {
      logic                 big_endian_length;
      logic [MAX_LEN_W-1:0] max_frame_len;
      logic [CMD_W-1:0]     num_commands;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic [KIND_W-1:0] byte_kind;
      logic [CMD_W-1:0]  command_index;
      logic              command_valid;
      logic              long_length;
      logic [LEN_W-1:0]  payload_length;
      logic              frame_last;
      logic              too_long;
      logic              halted;
   } rsp_type;

endpackage

// ===== design/lpfs_csr.sv =====
// ---------------------------------------------------------------------------
// lpfs_csr
// Configuration registers of the frame splitter; always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpfs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output lpfs_pkg::cfg_type                 cfg
);
   import lpfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_BIG_ENDIAN:   cfg_in.big_endian_length = csr_wdata[0];
            REG_MAX_FRAME:    cfg_in.max_frame_len     = csr_wdata[MAX_LEN_W-1:0];
            REG_NUM_COMMANDS: cfg_in.num_commands      = csr_wdata[CMD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.big_endian_length <= 1'b0;
         cfg_ff.max_frame_len     <= MAX_FRAME_RESET;
         cfg_ff.num_commands      <= NUM_COMMANDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/lpfs_parser.sv =====
// ---------------------------------------------------------------------------
// lpfs_parser
// Frame state and per-byte tagging; state advances when step is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfs_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [lpfs_pkg::BYTE_W-1:0]  stream_byte,
   input  lpfs_pkg::cfg_type            cfg,
   output lpfs_pkg::rsp_type            rsp
);
   import lpfs_pkg::*;

   phase_type         phase_ff, phase_in;
   logic              wide_ff, wide_in;
   logic [1:0]        seen_ff, seen_in;
   logic [LEN_W-1:0]  accum_ff, accum_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic              cval_ff, cval_in;
   logic              stopped_ff, stopped_in;

   logic [LEN_W-1:0]  accum_new;
   logic [LEN_W:0]    total;
   logic [LEN_W-1:0]  left_dec;
   logic [CMD_W-1:0]  cmd_id;
   logic [CMD_W-1:0]  cmd_idx;
   logic              len_done;

   always_comb begin
      phase_in   = phase_ff;
      wide_in    = wide_ff;
      seen_in    = seen_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      cmd_in     = cmd_ff;
      cval_in    = cval_ff;
      stopped_in = stopped_ff;

      accum_new = cfg.big_endian_length
                  ? {accum_ff[LEN_W-9:0], stream_byte}
                  : accum_ff | ({24'd0, stream_byte} << {seen_ff, 3'b000});
      total     = {1'b0, accum_new} + (wide_ff ? 33'd5 : 33'd3);
      left_dec  = left_ff - 32'd1;
      cmd_id    = stream_byte[CMD_W-1:0];
      cmd_idx   = cmd_id - 7'd1;
      len_done  = wide_ff ? (seen_ff == 2'd3) : (seen_ff != 2'd0);

      rsp = '0;
      rsp.byte_value = stream_byte;

      if (stopped_ff) begin
         rsp.byte_kind = KIND_DROP;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               accum_in           = accum_new;
               seen_in            = seen_ff + 2'd1;
               rsp.byte_kind      = KIND_LEN;
               rsp.command_index  = cmd_ff;
               rsp.command_valid  = cval_ff;
               rsp.long_length    = wide_ff;
               rsp.payload_length = accum_new;
               if (len_done) begin
                  if (total >= {15'd0, cfg.max_frame_len}) begin
                     rsp.too_long = 1'b1;
                     stopped_in   = 1'b1;
                     phase_in     = PH_CMD;
                  end else if (accum_new == '0) begin
                     rsp.frame_last = 1'b1;
                     phase_in       = PH_CMD;
                  end else begin
                     left_in  = accum_new;
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               left_in            = left_dec;
               rsp.byte_kind      = KIND_PAY;
               rsp.command_index  = cmd_ff;
               rsp.command_valid  = cval_ff;
               rsp.long_length    = wide_ff;
               rsp.payload_length = accum_ff;
               if (left_dec == '0) begin
                  rsp.frame_last = 1'b1;
                  phase_in       = PH_CMD;
               end
            end
            default: begin
               // command byte; unused phase code lands here too
               cmd_in            = cmd_idx;
               cval_in           = (cmd_id != '0) && (cmd_idx < cfg.num_commands);
               wide_in           = stream_byte[BYTE_W-1];
               seen_in           = 2'd0;
               accum_in          = '0;
               left_in           = '0;
               phase_in          = PH_LEN;
               rsp.byte_kind     = KIND_CMD;
               rsp.command_index = cmd_idx;
               rsp.command_valid = cval_in;
               rsp.long_length   = wide_in;
            end
         endcase
      end
      rsp.halted = stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CMD;
         wide_ff    <= 1'b0;
         seen_ff    <= 2'd0;
         accum_ff   <= '0;
         left_ff    <= '0;
         cmd_ff     <= '0;
         cval_ff    <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         wide_ff    <= wide_in;
         seen_ff    <= seen_in;
         accum_ff   <= accum_in;
         left_ff    <= left_in;
         cmd_ff     <= cmd_in;
         cval_ff    <= cval_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== design/length_prefixed_frame_splitter_unit.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_frame_splitter_unit
// Pipeline: an accepted request byte is registered in stage 1 and its tagged
// response in stage 2; a full stage 2 that is not being read stalls stage 1.
// Throughput: 1 request per cycle while rsp_ready holds, one parser step each.
// Reset: synchronous, active high; empties both stages, frame state back to
// expecting a command byte, registers to their defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_frame_splitter_unit_macros.svh"

module length_prefixed_frame_splitter_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel: one stream byte per request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lpfs_pkg::BYTE_W-1:0]       req_stream_byte,
   // response channel: one tagged byte per request
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lpfs_pkg::BYTE_W-1:0]       rsp_byte_value,
   output logic [lpfs_pkg::KIND_W-1:0]       rsp_byte_kind,
   output logic [lpfs_pkg::CMD_W-1:0]        rsp_command_index,
   output logic                              rsp_command_valid,
   output logic                              rsp_long_length,
   output logic [lpfs_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic                              rsp_frame_last,
   output logic                              rsp_too_long,
   output logic                              rsp_halted,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lpfs_pkg::*;

   // Stage 1: input register holding one request byte.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // Stage 2: response register.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   cfg_type           cfg;
   rsp_type           rsp_next;
   logic              advance;
   logic              req_take;

   // Stage 1 moves into stage 2 when the response slot is free or draining.
   // The parser state steps on exactly these cycles, one byte each.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   lpfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpfs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .cfg         (cfg),
      .rsp         (rsp_next)
   );

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_stream_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_value     = rsp_ff.byte_value;
   assign rsp_byte_kind      = rsp_ff.byte_kind;
   assign rsp_command_index  = rsp_ff.command_index;
   assign rsp_command_valid  = rsp_ff.command_valid;
   assign rsp_long_length    = rsp_ff.long_length;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_frame_last     = rsp_ff.frame_last;
   assign rsp_too_long       = rsp_ff.too_long;
   assign rsp_halted         = rsp_ff.halted;

   // oversize detection always halts the stream on the same byte
   `LPFS_ASSERT_IMPL(a_too_long_halts, rsp_valid && rsp_too_long,
      rsp_halted && rsp_byte_kind == KIND_LEN && !rsp_frame_last,
      "too_long without halt on a length byte")
   // dropped bytes carry no frame tagging
   `LPFS_ASSERT_IMPL(a_drop_clean, rsp_valid && rsp_byte_kind == KIND_DROP,
      rsp_halted && !rsp_frame_last && !rsp_too_long && rsp_payload_length == '0,
      "dropped byte with frame fields set")
   // a halted response is never followed by a live one
   `LPFS_ASSERT_IMPL(a_halt_sticky, advance && rsp_valid_ff && rsp_halted,
      ##1 rsp_halted, "stream resumed after halt")

endmodule
